@@ rtl/crsn_pkg.sv @@
// ----------------------------------------------------------------------------
// crsn_pkg
// Shared types, widths and helpers for the Catmull-Rom segment normal block.
// ----------------------------------------------------------------------------
package crsn_pkg;

  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned PNT_W     = 32;
  localparam int unsigned OUT_W     = 18;
  localparam int unsigned DIR_W     = 39;
  localparam int unsigned MAG_W     = 38;
  localparam int unsigned MSB_W     = $clog2(MAG_W);
  localparam int unsigned NRM_W     = 30;
  localparam int unsigned NORM_MSB  = 29;
  localparam int unsigned SQ_W      = 2 * NRM_W;
  localparam int unsigned SUM_W     = 62;
  localparam int unsigned ISQ_W     = 64;
  localparam int unsigned ROOT_W    = 31;
  localparam int unsigned COEF_W    = 8;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  localparam logic signed [63:0] SAT_HI = 64'sd131071;
  localparam logic signed [63:0] SAT_LO = -64'sd131072;

  typedef logic signed [OUT_W-1:0] comp_t;
  typedef logic [2:0][OUT_W-1:0] vec_t;
  typedef logic [NUM_SLOTS-1:0][2:0][PNT_W-1:0] pts_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][2:0][OUT_W-1:0] tan;
    logic [NUM_SLOTS-1:0][2:0][OUT_W-1:0] nrm;
    logic [NUM_SLOTS-1:0]                 zero;
  } seg_t;

  // derivative weights per slot, times 32 for slots 1 and 2, times 2 for slots 0 and 3
  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] slot,
                                                    input logic [1:0] idx);
    logic [3:0][COEF_W-1:0] row;
    unique case (slot)
      2'd0:    row = {8'sd0, 8'sd1, 8'sd0, -8'sd1};
      2'd1:    row = {-8'sd5, 8'sd39, -8'sd31, -8'sd3};
      2'd2:    row = {8'sd3, 8'sd31, -8'sd39, 8'sd5};
      default: row = {8'sd1, 8'sd0, -8'sd1, 8'sd0};
    endcase
    return $signed(row[idx]);
  endfunction

  function automatic comp_t sat18(input logic signed [63:0] v);
    comp_t r;
    priority if (v > SAT_HI) r = comp_t'(SAT_HI);
    else if (v < SAT_LO)     r = comp_t'(SAT_LO);
    else                     r = comp_t'(v);
    return r;
  endfunction

endpackage

@@ rtl/crsn_isqrt.sv @@
// ----------------------------------------------------------------------------
// crsn_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module crsn_isqrt import crsn_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NS = ROOT_W + 1;

  logic [ISQ_W-1:0]  x_q [NS];
  logic [ISQ_W-1:0]  r_q [NS];
  logic [SIDE_W-1:0] s_q [NS];
  logic              v_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stg
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (NS - 1 - i));
    logic [ISQ_W-1:0]  x_in, r_in, trial;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (i == 0) begin : g_first
      assign x_in = ISQ_W'(sum_i);
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = vld_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign r_in = r_q[i-1];
      assign s_in = s_q[i-1];
      assign v_in = v_q[i-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i] <= s_in;
        if (x_in >= trial) begin
          x_q[i] <= x_in - trial;
          r_q[i] <= (r_in >> 1) + BIT;
        end else begin
          x_q[i] <= x_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = v_q[NS-1];
  assign root_o = ROOT_W'(r_q[NS-1]);
  assign side_o = s_q[NS-1];

endmodule

@@ rtl/crsn_div.sv @@
// ----------------------------------------------------------------------------
// crsn_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module crsn_div import crsn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 1,
  localparam int unsigned NW       = FRAC_BITS + 32,
  localparam int unsigned QB       = FRAC_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NW-1:0]     num_i,
  input  logic [ROOT_W-1:0] den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QB-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NW-1:0]     rem_q [QB];
  logic [ROOT_W-1:0] den_q [QB];
  logic [QB-1:0]     quo_q [QB];
  logic [SIDE_W-1:0] s_q   [QB];
  logic              v_q   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stg
    logic [NW-1:0]     rem_in, dsh;
    logic [ROOT_W-1:0] den_in;
    logic [QB-1:0]     quo_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign s_in   = side_i;
      assign v_in   = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign s_in   = s_q[i-1];
      assign v_in   = v_q[i-1];
    end

    assign dsh = NW'(den_in) << (QB - 1 - i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i]   <= s_in;
        den_q[i] <= den_in;
        if (rem_in >= dsh) begin
          rem_q[i] <= rem_in - dsh;
          quo_q[i] <= {quo_in[QB-2:0], 1'b1};
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= {quo_in[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = v_q[QB-1];
  assign quo_o  = quo_q[QB-1];
  assign side_o = s_q[QB-1];

endmodule

@@ rtl/crsn_tangent.sv @@
// ----------------------------------------------------------------------------
// crsn_tangent
// Unit tangent of one slot: derivative, block scaling, root and division.
// ----------------------------------------------------------------------------
module crsn_tangent import crsn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SLOT      = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  pts_t pts_i,
  output logic vld_o,
  output vec_t tan_o,
  output logic zero_o
);

  localparam int unsigned NW     = FRAC_BITS + 32;
  localparam int unsigned QB     = FRAC_BITS + 1;
  localparam int unsigned SIDE_W = 1 + 3 + 3 * NRM_W;

  // derivative
  logic signed [DIR_W-1:0] dir_d [3];
  logic signed [DIR_W-1:0] dir_q [3];
  logic                    v1_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dir_d[c] = '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        dir_d[c] = dir_d[c] + DIR_W'(coef(2'(SLOT), 2'(j))) *
                   DIR_W'($signed(pts_i[j][c]));
      end
    end
  end

  // magnitudes and maximum
  logic [MAG_W-1:0] mag_d [3];
  logic [MAG_W-1:0] mag2_q [3];
  logic [MAG_W-1:0] max_d, max_q;
  logic [2:0]       neg2_q;
  logic             v2_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag_d[c] = dir_q[c][DIR_W-1] ? MAG_W'(-dir_q[c]) : MAG_W'(dir_q[c]);
    end
    max_d = mag_d[0];
    if (mag_d[1] > max_d) max_d = mag_d[1];
    if (mag_d[2] > max_d) max_d = mag_d[2];
  end

  // leading one
  logic [MSB_W-1:0] msb_d, msb_q;
  logic [MAG_W-1:0] mag3_q [3];
  logic [2:0]       neg3_q;
  logic             zero3_q;
  logic             v3_q;

  always_comb begin
    msb_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (max_q[b]) msb_d = MSB_W'(b);
    end
  end

  // block scaling
  logic [NRM_W-1:0] nm_d [3];
  logic [NRM_W-1:0] nm4_q [3];
  logic [2:0]       neg4_q;
  logic             zero4_q;
  logic             v4_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (msb_q >= MSB_W'(NORM_MSB)) begin
        nm_d[c] = NRM_W'(mag3_q[c] >> (msb_q - MSB_W'(NORM_MSB)));
      end else begin
        nm_d[c] = NRM_W'(mag3_q[c] << (MSB_W'(NORM_MSB) - msb_q));
      end
    end
  end

  // squares
  logic [SQ_W-1:0]  sq_q [3];
  logic [NRM_W-1:0] nm5_q [3];
  logic [2:0]       neg5_q;
  logic             zero5_q;
  logic             v5_q;

  // sum of squares
  logic [SUM_W-1:0]  sum_q;
  logic [SIDE_W-1:0] side6_q;
  logic              v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        dir_q[c]  <= dir_d[c];
        mag2_q[c] <= mag_d[c];
        neg2_q[c] <= dir_q[c][DIR_W-1];
        mag3_q[c] <= mag2_q[c];
        nm4_q[c]  <= nm_d[c];
        sq_q[c]   <= SQ_W'(nm4_q[c]) * SQ_W'(nm4_q[c]);
        nm5_q[c]  <= nm4_q[c];
      end
      max_q   <= max_d;
      msb_q   <= msb_d;
      neg3_q  <= neg2_q;
      zero3_q <= (max_q == '0);
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      sum_q   <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      side6_q <= {zero5_q, neg5_q, nm5_q[2], nm5_q[1], nm5_q[0]};
    end
  end

  // root
  logic              vr;
  logic [ROOT_W-1:0] root;
  logic [SIDE_W-1:0] side_r;

  crsn_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v6_q),
    .sum_i  (sum_q),
    .side_i (side6_q),
    .vld_o  (vr),
    .root_o (root),
    .side_o (side_r)
  );

  // dividend with rounding term
  logic [NW-1:0]     num_q [3];
  logic [ROOT_W-1:0] den_q;
  logic [2:0]        neg8_q;
  logic              zero8_q;
  logic              v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en_i) begin
      v8_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        num_q[c] <= (NW'(side_r[c*NRM_W +: NRM_W]) << FRAC_BITS) + NW'(root >> 1);
      end
      den_q   <= root;
      neg8_q  <= side_r[3*NRM_W +: 3];
      zero8_q <= side_r[SIDE_W-1];
    end
  end

  // division
  logic          vd [3];
  logic [QB-1:0] quo [3];
  logic [1:0]    side_d [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    crsn_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (v8_q),
      .num_i  (num_q[c]),
      .den_i  (den_q),
      .side_i ({zero8_q, neg8_q[c]}),
      .vld_o  (vd[c]),
      .quo_o  (quo[c]),
      .side_o (side_d[c])
    );
  end

  // sign and saturation
  logic signed [63:0] qv [3];
  vec_t               tan_d, tan_q;
  logic               zero_q, vo_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qv[c] = 64'(quo[c]);
      if (side_d[c][0]) qv[c] = -qv[c];
      tan_d[c] = side_d[0][1] ? '0 : sat18(qv[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vd[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tan_q  <= tan_d;
      zero_q <= side_d[0][1];
    end
  end

  assign vld_o  = vo_q;
  assign tan_o  = tan_q;
  assign zero_o = zero_q;

endmodule

@@ rtl/crsn_cross.sv @@
// ----------------------------------------------------------------------------
// crsn_cross
// Normal of one slot: T x (prev x T), rounded twice, over four stages.
// ----------------------------------------------------------------------------
module crsn_cross import crsn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned K         = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  seg_t seg_i,
  output logic vld_o,
  output seg_t seg_o
);

  localparam int unsigned PW = 2 * OUT_W;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned TW = 38 - FRAC_BITS;
  localparam int unsigned CW = TW + OUT_W;
  localparam int unsigned BW = CW + 1;
  localparam logic signed [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [BW-1:0] HALF_B = BW'(1) << (FRAC_BITS - 1);

  logic va_q, vb_q, vc_q, vd_q;
  seg_t sa_q, sb_q, sc_q, sd_q;

  // stage a: T x prev products
  comp_t t0, t1, t2, p0, p1, p2;
  logic signed [PW-1:0] pa_q [6];

  assign t0 = seg_i.tan[K][0];
  assign t1 = seg_i.tan[K][1];
  assign t2 = seg_i.tan[K][2];
  assign p0 = seg_i.nrm[K-1][0];
  assign p1 = seg_i.nrm[K-1][1];
  assign p2 = seg_i.nrm[K-1][2];

  // stage b: differences and rounding
  logic signed [AW-1:0] da [3];
  logic signed [TW-1:0] tmp_d [3];
  logic signed [TW-1:0] tmp_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      da[c]    = AW'(pa_q[2*c]) - AW'(pa_q[2*c+1]);
      tmp_d[c] = TW'((da[c] + HALF_A) >>> FRAC_BITS);
    end
  end

  // stage c: tmp x T products
  comp_t u0, u1, u2;
  logic signed [CW-1:0] pc_q [6];

  assign u0 = sb_q.tan[K][0];
  assign u1 = sb_q.tan[K][1];
  assign u2 = sb_q.tan[K][2];

  // stage d: differences, rounding, saturation
  logic signed [BW-1:0] db [3];
  seg_t                 sd_d;

  always_comb begin
    sd_d = sc_q;
    for (int c = 0; c < 3; c++) begin
      db[c] = BW'(pc_q[2*c]) - BW'(pc_q[2*c+1]);
      sd_d.nrm[K][c] = sc_q.zero[K] ? '0 : sat18(64'((db[c] + HALF_B) >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q    <= seg_i;
      pa_q[0] <= PW'(t1) * PW'(p2);
      pa_q[1] <= PW'(t2) * PW'(p1);
      pa_q[2] <= PW'(t2) * PW'(p0);
      pa_q[3] <= PW'(t0) * PW'(p2);
      pa_q[4] <= PW'(t0) * PW'(p1);
      pa_q[5] <= PW'(t1) * PW'(p0);
      sb_q    <= sa_q;
      for (int c = 0; c < 3; c++) tmp_q[c] <= tmp_d[c];
      sc_q    <= sb_q;
      pc_q[0] <= CW'(tmp_q[1]) * CW'(u2);
      pc_q[1] <= CW'(tmp_q[2]) * CW'(u1);
      pc_q[2] <= CW'(tmp_q[2]) * CW'(u0);
      pc_q[3] <= CW'(tmp_q[0]) * CW'(u2);
      pc_q[4] <= CW'(tmp_q[0]) * CW'(u1);
      pc_q[5] <= CW'(tmp_q[1]) * CW'(u0);
      sd_q    <= sd_d;
    end
  end

  assign vld_o = vd_q;
  assign seg_o = sd_q;

endmodule

@@ rtl/catmull_rom_segment_normals.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_segment_normals
// Unit tangents and normals of a Catmull-Rom segment at t = 0, .25, .75, 1.
//
// A request on the input channel carries one segment: four control points,
// each coordinate signed Q16.16. For every segment the block returns four
// requests on the output channel, slots 0 to 3 in order, each with the unit
// tangent and the normal in signed Q2.16, a zero-tangent flag and a
// last-of-segment flag on slot 3.
// From input acceptance to slot 0 a segment passes the tangent units with
// their square root and dividers, three normal steps of four stages each
// and the output register. The output register emits one request per
// cycle while out_ready_i is high; a new segment is taken only when that
// register is empty or its slot 3 request leaves.
// Reset clears all valid bits; payload state is not reset and is not needed.
// When the receiver holds out_ready_i low while a result is waiting, the whole
// pipeline holds in place and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module catmull_rom_segment_normals import crsn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PNT_W-1:0] p0_x_i,
  input  logic [PNT_W-1:0] p0_y_i,
  input  logic [PNT_W-1:0] p0_z_i,
  input  logic [PNT_W-1:0] p1_x_i,
  input  logic [PNT_W-1:0] p1_y_i,
  input  logic [PNT_W-1:0] p1_z_i,
  input  logic [PNT_W-1:0] p2_x_i,
  input  logic [PNT_W-1:0] p2_y_i,
  input  logic [PNT_W-1:0] p2_z_i,
  input  logic [PNT_W-1:0] p3_x_i,
  input  logic [PNT_W-1:0] p3_y_i,
  input  logic [PNT_W-1:0] p3_z_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       point_slot_o,
  output logic [OUT_W-1:0] normal_x_o,
  output logic [OUT_W-1:0] normal_y_o,
  output logic [OUT_W-1:0] normal_z_o,
  output logic [OUT_W-1:0] unit_tangent_x_o,
  output logic [OUT_W-1:0] unit_tangent_y_o,
  output logic [OUT_W-1:0] unit_tangent_z_o,
  output logic             zero_tangent_o,
  output logic             last_of_item_o
);

  logic adv;
  pts_t pts;

  assign pts[0] = {p0_z_i, p0_y_i, p0_x_i};
  assign pts[1] = {p1_z_i, p1_y_i, p1_x_i};
  assign pts[2] = {p2_z_i, p2_y_i, p2_x_i};
  assign pts[3] = {p3_z_i, p3_y_i, p3_x_i};

  // tangent units, one per slot
  logic [NUM_SLOTS-1:0] tv;
  vec_t                 tan [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tz;

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_tan
    crsn_tangent #(.FRAC_BITS(FRAC_BITS), .SLOT(s)) u_tan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (in_valid_i),
      .pts_i  (pts),
      .vld_o  (tv[s]),
      .tan_o  (tan[s]),
      .zero_o (tz[s])
    );
  end

  // segment frame, slot 0 normal is the swizzled tangent
  seg_t seg0;

  always_comb begin
    seg0 = '0;
    for (int s = 0; s < NUM_SLOTS; s++) seg0.tan[s] = tan[s];
    seg0.zero      = tz;
    seg0.nrm[0][0] = tan[0][1];
    seg0.nrm[0][1] = tan[0][2];
    seg0.nrm[0][2] = tan[0][0];
  end

  // normal chain
  logic cv [NUM_SLOTS];
  seg_t cs [NUM_SLOTS];

  assign cv[0] = &tv;
  assign cs[0] = seg0;

  for (genvar k = 1; k < NUM_SLOTS; k++) begin : g_crs
    crsn_cross #(.FRAC_BITS(FRAC_BITS), .K(k)) u_crs (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (cv[k-1]),
      .seg_i  (cs[k-1]),
      .vld_o  (cv[k]),
      .seg_o  (cs[k])
    );
  end

  // output register, one slot per cycle while out_ready_i is high
  logic       ser_vld_q;
  logic [1:0] slot_q;
  seg_t       ser_q;

  assign adv = !ser_vld_q || (out_ready_i && slot_q == LAST_SLOT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      slot_q    <= '0;
    end else if (adv) begin
      ser_vld_q <= cv[NUM_SLOTS-1];
      slot_q    <= '0;
    end else if (out_ready_i) begin
      slot_q <= slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ser_q <= cs[NUM_SLOTS-1];
    end
  end

  assign in_ready_o       = adv;
  assign out_valid_o      = ser_vld_q;
  assign point_slot_o     = slot_q;
  assign normal_x_o       = ser_q.nrm[slot_q][0];
  assign normal_y_o       = ser_q.nrm[slot_q][1];
  assign normal_z_o       = ser_q.nrm[slot_q][2];
  assign unit_tangent_x_o = ser_q.tan[slot_q][0];
  assign unit_tangent_y_o = ser_q.tan[slot_q][1];
  assign unit_tangent_z_o = ser_q.tan[slot_q][2];
  assign zero_tangent_o   = ser_q.zero[slot_q];
  assign last_of_item_o   = (slot_q == LAST_SLOT);

endmodule

@@ dv/tb_catmull_rom_segment_normals.sv @@
// ----------------------------------------------------------------------------
// tb_catmull_rom_segment_normals
// Checks tangent and normal frames of Catmull-Rom segments against a predictor.
//
// A table of directed segments runs first. Random segments follow, mostly
// smooth curves, with some noise and degenerate ones. The sender works in
// bursts and the receiver stalls, once for a long stretch. Every result is
// compared field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
module tb_catmull_rom_segment_normals;
  import crsn_pkg::*;

  localparam int unsigned N_RANDOM   = 220;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYC  = 120;
  localparam logic [31:0] P_MAX = 32'h7fff_ffff;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] P_ONE = 32'h0001_0000;

  typedef logic [11:0][31:0] seg_pts_t;

  typedef struct packed {
    logic [1:0]       slot;
    logic [OUT_W-1:0] nx, ny, nz, tx, ty, tz;
    logic             zero, last;
  } frame_t;

  typedef struct packed {
    seg_pts_t pts;
    logic     all_zero;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  seg_pts_t pin;
  logic [1:0] point_slot_o;
  logic [OUT_W-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [OUT_W-1:0] unit_tangent_x_o, unit_tangent_y_o, unit_tangent_z_o;
  logic zero_tangent_o, last_of_item_o;

  frame_t frame_q[$];
  bit     failed;
  bit     sender_done;
  int     n_accepted;
  int     idle_cyc;

  catmull_rom_segment_normals dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .p0_x_i(pin[0]), .p0_y_i(pin[1]), .p0_z_i(pin[2]),
    .p1_x_i(pin[3]), .p1_y_i(pin[4]), .p1_z_i(pin[5]),
    .p2_x_i(pin[6]), .p2_y_i(pin[7]), .p2_z_i(pin[8]),
    .p3_x_i(pin[9]), .p3_y_i(pin[10]), .p3_z_i(pin[11]),
    .out_valid_o, .out_ready_i, .point_slot_o,
    .normal_x_o, .normal_y_o, .normal_z_o,
    .unit_tangent_x_o, .unit_tangent_y_o, .unit_tangent_z_o,
    .zero_tangent_o, .last_of_item_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint clamp18(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint rnd_frac(input longint v);
    return (v + (longint'(1) << 15)) >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_dir(input longint d[3], output longint u[3]);
    longint unsigned mag[3], m, sum, len, q;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 1'b0;
    while (m >= (longint'(1) << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (longint'(1) << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 16) + (len >> 1)) / len;
      u[i] = clamp18(d[i] < 0 ? -longint'(q) : longint'(q));
    end
    return 1'b1;
  endfunction

  function automatic void cross_rnd(input longint a[3], input longint b[3],
                                    output longint r[3]);
    r[0] = rnd_frac(a[1] * b[2] - a[2] * b[1]);
    r[1] = rnd_frac(a[2] * b[0] - a[0] * b[2]);
    r[2] = rnd_frac(a[0] * b[1] - a[1] * b[0]);
  endfunction

  task automatic predict_frames(input seg_pts_t s);
    int     wt[4][4] = '{'{-1, 0, 1, 0}, '{-3, -31, 39, -5},
                         '{5, -39, 31, 3}, '{0, -1, 0, 1}};
    longint d[3], t[3], n[3], tmp[3], prev[3];
    bit     ok;
    frame_t f;
    prev = '{0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        d[c] = 0;
        for (int j = 0; j < 4; j++)
          d[c] += longint'(wt[k][j]) * longint'($signed(s[j*3+c]));
      end
      ok = unit_dir(d, t);
      if (!ok) begin
        n = '{0, 0, 0};
      end else if (k == 0) begin
        n = '{t[1], t[2], t[0]};
      end else begin
        cross_rnd(t, prev, tmp);
        cross_rnd(tmp, t, n);
        for (int c = 0; c < 3; c++) n[c] = clamp18(n[c]);
      end
      f.slot = 2'(k);
      f.nx = OUT_W'(n[0]); f.ny = OUT_W'(n[1]); f.nz = OUT_W'(n[2]);
      f.tx = OUT_W'(t[0]); f.ty = OUT_W'(t[1]); f.tz = OUT_W'(t[2]);
      f.zero = !ok;
      f.last = (2'(k) == LAST_SLOT);
      frame_q.push_back(f);
      prev = n;
    end
  endtask

  // ---------------- stimulus ----------------
  function automatic logic [31:0] near(input logic [31:0] base);
    logic [31:0] dlt;
    dlt = $urandom >> $urandom_range(4, 31);
    return $urandom_range(0, 1) ? base + dlt : base - dlt;
  endfunction

  function automatic seg_pts_t rand_seg();
    seg_pts_t s;
    logic [31:0] pick[3] = '{P_MAX, P_MIN, 32'h0};
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      case (kind)
        6:       s[i] = $urandom;
        7:       s[i] = $urandom_range(0, 6) - 3;
        9:       s[i] = pick[$urandom_range(0, 2)];
        default: s[i] = (i < 3) ? $urandom : near(s[i-3]);
      endcase
    end
    if (kind == 8) begin
      // repeated coordinates can give zero tangents at the ends
      for (int c = 0; c < 3; c++) begin
        if ($urandom_range(0, 1)) s[6+c] = s[c];
        if ($urandom_range(0, 1)) s[9+c] = s[3+c];
      end
    end
    return s;
  endfunction

  task automatic send_seg(input seg_pts_t s, input logic all_zero);
    pin        <= s;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_accepted++;
    if (all_zero) begin
      for (int k = 0; k < 4; k++)
        frame_q.push_back('{slot: 2'(k), nx: '0, ny: '0, nz: '0, tx: '0,
                            ty: '0, tz: '0, zero: 1'b1,
                            last: (2'(k) == LAST_SLOT)});
    end else begin
      predict_frames(s);
    end
    @(negedge clk_i);
  endtask

  row_t dir_rows[$];
  int   burst_left;

  initial begin
    seg_pts_t s;
    int       gap;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pin = '0;
    sender_done = 1'b0;
    n_accepted = 0;
    failed = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir_rows.push_back('{'0, 1'b1});
    s = '0; s[6] = 32'h1;            dir_rows.push_back('{s, 1'b0});
    s = '0; s[6] = P_ONE;            dir_rows.push_back('{s, 1'b0});
    s = '0; s[7] = P_MAX;            dir_rows.push_back('{s, 1'b0});
    s = '0; s[8] = P_MIN;            dir_rows.push_back('{s, 1'b0});
    s = '0; s[9] = P_ONE;            dir_rows.push_back('{s, 1'b0});
    s = '0; s[3] = P_MIN; s[4] = P_MAX; dir_rows.push_back('{s, 1'b0});
    s = {12{P_MAX}};                 dir_rows.push_back('{s, 1'b0});
    s = {12{P_MIN}};                 dir_rows.push_back('{s, 1'b0});
    s = {6{P_MAX, P_MIN}};           dir_rows.push_back('{s, 1'b0});
    s = {6{P_MIN, P_MAX}};           dir_rows.push_back('{s, 1'b0});
    s = {3{P_MIN, P_MAX, P_MIN, 32'h0}}; dir_rows.push_back('{s, 1'b0});
    s = {{3{P_MAX}}, {3{P_MIN}}, {3{P_MAX}}, {3{P_MIN}}};
    dir_rows.push_back('{s, 1'b0});
    s = {{3{P_MIN}}, {3{P_MAX}}, {3{P_MIN}}, {3{P_MAX}}};
    dir_rows.push_back('{s, 1'b0});
    s = {{3{P_ONE}}, 96'h0, {3{P_ONE}}, 96'h0}; dir_rows.push_back('{s, 1'b0});
    s = {12{32'hffff_ffff}};         dir_rows.push_back('{s, 1'b0});
    s = {12{32'h5555_aaaa}};         dir_rows.push_back('{s, 1'b0});
    for (int i = 0; i < 12; i++) s[i] = 32'(i) * P_ONE;
    dir_rows.push_back('{s, 1'b0});
    foreach (dir_rows[i]) send_seg(dir_rows[i].pts, dir_rows[i].all_zero);

    burst_left = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      send_seg(rand_seg(), 1'b0);
    end
    in_valid_i <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver stall patterns, one long hold-off while the sender keeps going
  initial begin
    int mode, span;
    bit held;
    out_ready_i = 1'b0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        if (!held && n_accepted >= 40) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (400) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= (i % 3) != 0;
          2:       out_ready_i <= $urandom_range(0, 9) < 7;
          default: out_ready_i <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // ---------------- checking ----------------
  function automatic void cmp(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, name,
               exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_q.size() == 0) begin
        $display("%0t unexpected result slot %0d", $realtime, point_slot_o);
        failed = 1'b1;
      end else begin
        e = frame_q.pop_front();
        cmp("point_slot", e.slot, point_slot_o);
        cmp("normal_x", e.nx, normal_x_o);
        cmp("normal_y", e.ny, normal_y_o);
        cmp("normal_z", e.nz, normal_z_o);
        cmp("unit_tangent_x", e.tx, unit_tangent_x_o);
        cmp("unit_tangent_y", e.ty, unit_tangent_y_o);
        cmp("unit_tangent_z", e.tz, unit_tangent_z_o);
        cmp("zero_tangent", e.zero, zero_tangent_o);
        cmp("last_of_item", e.last, last_of_item_o);
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    idle_cyc = 0;
    wait (sender_done);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (!failed && frame_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
